[rtl/core/pev_pkg.sv]
`default_nettype none
package pev_pkg;

  localparam int unsigned ChannelsDefault  = 3;
  localparam int unsigned CountBitsDefault = 16;

  typedef enum logic [3:0] {
    CmdTick    = 4'd0,
    CmdToneWr  = 4'd1,
    CmdPlainWr = 4'd2,
    CmdVolume  = 4'd3,
    CmdAdsr    = 4'd4,
    CmdVibrato = 4'd5,
    CmdToneSet = 4'd6,
    CmdPerc    = 4'd7,
    CmdNoise   = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    ModeOff     = 3'd0,
    ModeAttack  = 3'd1,
    ModeDecay   = 3'd2,
    ModeSustain = 3'd3,
    ModeRelease = 3'd4,
    ModeEnabled = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    BkIdle,
    BkExec,
    BkEmit
  } bk_state_e;

  typedef struct packed {
    logic [3:0]         command;
    logic [1:0]         channel;
    logic [6:0]         address;
    logic [7:0]         data;
    logic signed [15:0] count_a;
    logic [14:0]        count_b;
    logic [14:0]        count_c;
    logic [7:0]         level;
    logic [11:0]        period;
    logic               retrigger;
  } in_item_t;

  typedef struct packed {
    logic [6:0] reg_address;
    logic [7:0] reg_data;
    logic       last;
  } out_item_t;

endpackage
`default_nettype wire

[rtl/core/pev_front.sv]
`default_nettype none
module pev_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pev_pkg::in_item_t in_item_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output pev_pkg::in_item_t q_item_o
);
  import pev_pkg::*;

  // two-entry queue, unknown commands dropped here
  in_item_t   mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop, known;

  assign known      = in_item_i.command <= 4'(CmdNoise);
  assign in_ready_o = cnt_q != 2'd2;
  assign push       = in_valid_i && in_ready_o && known;
  assign q_valid_o  = cnt_q != 2'd0;
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q ^ push;
    rp_d  = rp_q ^ pop;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end
endmodule
`default_nettype wire

[rtl/core/pev_back.sv]
`default_nettype none
module pev_back #(
  parameter int unsigned CHANNELS   = pev_pkg::ChannelsDefault,
  parameter int unsigned COUNT_BITS = pev_pkg::CountBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  pev_pkg::in_item_t  q_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pev_pkg::out_item_t out_item_o,
  output logic               busy_o
);
  import pev_pkg::*;

  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned NB = COUNT_BITS;
  localparam logic [NB-1:0] CountMax = {1'b0, {(NB-1){1'b1}}};

  logic [7:0]    vol_q   [CHANNELS];
  logic [11:0]   tp_q    [CHANNELS];
  logic [3:0]    vel_q   [CHANNELS];
  logic          hw_q    [CHANNELS];
  logic          perc_q  [CHANNELS];
  logic [1:0]    pend_q  [CHANNELS];
  mode_e         mode_q  [CHANNELS];
  logic [NB-1:0] ecnt_q  [CHANNELS];
  logic [NB-1:0] atk_q   [CHANNELS];
  logic [NB-1:0] dec_q   [CHANNELS];
  logic [7:0]    sus_q   [CHANNELS];
  logic [NB-1:0] rel_q   [CHANNELS];
  logic          von_q   [CHANNELS];
  logic [NB-1:0] vcnt_q  [CHANNELS];
  logic [NB-1:0] vrate_q [CHANNELS];
  logic [NB-1:0] vdel_q  [CHANNELS];
  logic [7:0]    vdep_q  [CHANNELS];
  logic [7:0]    vstep_q [CHANNELS];
  logic          vdown_q [CHANNELS];

  bk_state_e state_q, state_d;
  in_item_t  it_q;
  logic [CW-1:0] ch_q;   // tick walk channel
  logic [1:0]    ph_q;   // tick phase: 0 env, 1 vib, 2 emit
  logic [1:0]    sub_q;  // emit sub-step within channel
  out_item_t     ob_q;
  logic          ob_v_q;

  function automatic logic [NB-1:0] sat(input logic [15:0] v);
    logic [NB-1:0] r;
    if (NB >= 17) r = NB'(v);
    else if (v > 16'(CountMax)) r = CountMax;
    else r = NB'(v);
    return r;
  endfunction

  // volume application on one channel
  typedef struct packed {
    logic [7:0]    vol;
    logic [3:0]    vel;
    logic          hw;
    logic          setvol;
    mode_e         mode;
    logic [NB-1:0] ecnt;
    logic          vib;
  } av_t;

  function automatic av_t av(input logic [7:0] vb, input mode_e m, input logic [NB-1:0] ec,
      input logic [NB-1:0] a, input logic [NB-1:0] d, input logic [7:0] s,
      input logic [NB-1:0] r, input logic p, input logic von);
    av_t o;
    logic [3:0] v;
    v = vb[3:0];
    o.vel = v; o.hw = vb[4]; o.vib = von; o.mode = m; o.ecnt = ec;
    o.setvol = 1'b0; o.vol = 8'd0;
    if (m != ModeOff) begin
      if (v != 4'd0) begin
        if (a != '0) begin
          o.mode = ModeAttack; o.ecnt = a; o.setvol = 1'b1; o.vol = 8'd0;
        end else if (d != '0) begin
          o.mode = ModeDecay; o.ecnt = d; o.setvol = 1'b1; o.vol = {4'd0, v};
        end else begin
          o.mode = ModeSustain; o.setvol = 1'b1; o.vol = s;
        end
      end else if (r != '0) begin
        o.mode = ModeRelease; o.ecnt = r;
      end else begin
        o.mode = ModeEnabled;
        o.setvol = !p;
      end
    end else begin
      o.setvol = !(v == 4'd0 && p);
      o.vol = {4'd0, v};
    end
    return o;
  endfunction

  logic [CW-1:0] c;
  logic          ok, tc_ok;
  logic [CW-1:0] tc;
  av_t           a_r;
  logic [7:0]    avb;
  logic          tick_done;

  assign c     = ch_q;
  assign tc    = CW'(it_q.address[6:1]);
  assign tc_ok = {26'd0, it_q.address[6:1]} < CHANNELS;
  assign ok    = {30'd0, it_q.channel} < CHANNELS;

  // single shared volume unit, addressed by the item channel
  logic [CW-1:0] ic;
  logic [NB-1:0] rel_in;
  assign ic     = CW'(it_q.channel);
  // noise loads the release count before the volume is reapplied
  assign rel_in = (it_q.command == 4'(CmdNoise) && it_q.data[7:6] != 2'd0) ?
                  sat({1'b0, it_q.count_c}) : rel_q[ic];
  assign avb = (it_q.command == 4'(CmdVolume)) ? it_q.data : {4'd0, vel_q[ic]};
  assign a_r = av(avb, mode_q[ic], ecnt_q[ic], atk_q[ic], dec_q[ic], sus_q[ic], rel_in,
                  perc_q[ic], von_q[ic]);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle: if (q_valid_i) state_d = BkExec;
      BkExec: begin
        if (it_q.command == 4'(CmdTick)) begin
          if (tick_done) state_d = BkIdle;
          else if (ph_q == 2'd2 && pend_q[c] != 2'd0) state_d = BkEmit;
        end else if (it_q.command == 4'(CmdToneWr) || it_q.command == 4'(CmdPlainWr) ||
                     it_q.command == 4'(CmdNoise)) begin
          state_d = BkEmit;
        end else begin
          state_d = BkIdle;
        end
      end
      BkEmit: if (!ob_v_q || out_ready_i) begin
        state_d = (it_q.command == 4'(CmdTick)) ? BkExec : BkIdle;
      end
      default: state_d = BkIdle;
    endcase
  end

  // last tick slot with nothing more to send
  logic more_after;
  always_comb begin
    more_after = 1'b0;
    for (int i = 0; i < CHANNELS; i++)
      if (i > int'(c) && pend_q[i] != 2'd0) more_after = 1'b1;
  end
  assign tick_done = ph_q == 2'd2 && pend_q[c] == 2'd0 && !more_after;

  // outputs
  assign q_ready_o   = state_q == BkIdle;
  assign out_valid_o = ob_v_q;
  assign out_item_o  = ob_q;
  assign busy_o      = state_q != BkIdle || ob_v_q;

  logic [NB-1:0] cntm1;
  logic [8:0]    vup, vdn;
  logic [7:0]    stp1;
  logic [12:0]   tpn;
  logic          vdn_n;
  always_comb begin
    cntm1 = (ecnt_q[c] != '0) ? ecnt_q[c] - 1'b1 : '0;
    if (ph_q == 2'd1) cntm1 = (vcnt_q[c] != '0) ? vcnt_q[c] - 1'b1 : '0;
    vup   = {1'b0, vol_q[c]} + 9'd1;
    vdn   = {1'b0, vol_q[c]} - 9'd1;
    stp1  = vstep_q[c] + 8'd1;
    vdn_n = (stp1 >= vdep_q[c]) ? !vdown_q[c] : vdown_q[c];
    tpn   = vdn_n ? {1'b0, tp_q[c]} - 13'd1 : {1'b0, tp_q[c]} + 13'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BkIdle;
      ch_q      <= '0;
      ph_q      <= '0;
      sub_q     <= '0;
      ob_v_q    <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        vol_q[i] <= 8'hff; tp_q[i] <= '0; vel_q[i] <= '0; hw_q[i] <= 1'b0;
        perc_q[i] <= 1'b0; pend_q[i] <= '0; mode_q[i] <= ModeOff; ecnt_q[i] <= '0;
        atk_q[i] <= '0; dec_q[i] <= '0; sus_q[i] <= '0; rel_q[i] <= '0;
        von_q[i] <= 1'b0; vcnt_q[i] <= '0; vrate_q[i] <= '0; vdel_q[i] <= '0;
        vdep_q[i] <= '0; vstep_q[i] <= '0; vdown_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (ob_v_q && out_ready_i) ob_v_q <= 1'b0;
      unique case (state_q)
        BkIdle: if (q_valid_i) begin
          ch_q <= '0; ph_q <= '0; sub_q <= '0;
        end
        BkExec: begin
          unique case (it_q.command)
            4'(CmdTick): begin
              if (ph_q == 2'd0) begin
                logic [8:0] nv; logic upd;
                upd = 1'b0; nv = '0;
                if (cntm1 == '0) begin
                  if (mode_q[c] == ModeAttack) begin
                    upd = 1'b1;
                    if (vup >= {5'd0, vel_q[c]}) begin
                      nv = {5'd0, vel_q[c]}; mode_q[c] <= ModeDecay; ecnt_q[c] <= dec_q[c];
                    end else begin
                      nv = vup; ecnt_q[c] <= atk_q[c];
                    end
                  end else if (mode_q[c] == ModeDecay) begin
                    upd = 1'b1;
                    if (vol_q[c] == 8'd0 || vdn[7:0] <= sus_q[c]) begin
                      nv = {1'b0, sus_q[c]}; mode_q[c] <= ModeSustain;
                      ecnt_q[c] <= rel_q[c];
                    end else begin
                      nv = vdn; ecnt_q[c] <= dec_q[c];
                    end
                  end else if (mode_q[c] == ModeRelease) begin
                    upd = 1'b1;
                    if (vol_q[c] <= 8'd1) begin
                      nv = '0; mode_q[c] <= ModeEnabled; ecnt_q[c] <= atk_q[c];
                    end else begin
                      nv = vdn; ecnt_q[c] <= rel_q[c];
                    end
                  end else begin
                    ecnt_q[c] <= cntm1;
                  end
                end else begin
                  ecnt_q[c] <= cntm1;
                end
                if (upd && vol_q[c] != {4'd0, nv[3:0]}) begin
                  vol_q[c]  <= {4'd0, nv[3:0]};
                  pend_q[c] <= pend_q[c] | 2'b01;
                end
                if (int'(c) == CHANNELS - 1) begin ch_q <= '0; ph_q <= 2'd1; end
                else ch_q <= c + 1'b1;
              end else if (ph_q == 2'd1) begin
                if (von_q[c]) begin
                  if (cntm1 == '0) begin
                    vcnt_q[c]  <= vrate_q[c];
                    vstep_q[c] <= (stp1 >= vdep_q[c]) ? 8'd0 : stp1;
                    vdown_q[c] <= vdn_n;
                    tp_q[c]    <= tpn[12] ? (vdn_n ? 12'd0 : 12'hfff) : tpn[11:0];
                    pend_q[c]  <= pend_q[c] | 2'b10;
                  end else begin
                    vcnt_q[c] <= cntm1;
                  end
                end
                if (int'(c) == CHANNELS - 1) begin ch_q <= '0; ph_q <= 2'd2; end
                else ch_q <= c + 1'b1;
              end else begin
                if (pend_q[c] != 2'd0) begin
                  ob_v_q <= 1'b1;
                  if (pend_q[c][0] && sub_q == 2'd0) begin
                    ob_q.reg_address <= 7'(8 + int'(c));
                    ob_q.reg_data    <= {3'd0, hw_q[c], vol_q[c][3:0]};
                    if (!pend_q[c][1]) begin
                      pend_q[c] <= '0; sub_q <= '0;
                      ob_q.last <= !more_after;
                      if (int'(c) != CHANNELS - 1) ch_q <= c + 1'b1;
                    end else begin
                      sub_q <= 2'd1;
                      ob_q.last <= 1'b0;
                    end
                  end else if (sub_q != 2'd2) begin
                    ob_q.reg_address <= 7'(2 * int'(c));
                    ob_q.reg_data    <= tp_q[c][7:0];
                    ob_q.last <= 1'b0;
                    sub_q <= 2'd2;
                  end else begin
                    ob_q.reg_address <= 7'(2 * int'(c) + 1);
                    ob_q.reg_data    <= {4'd0, tp_q[c][11:8]};
                    ob_q.last <= !more_after;
                    pend_q[c] <= '0; sub_q <= '0;
                    if (int'(c) != CHANNELS - 1) ch_q <= c + 1'b1;
                  end
                end else if (int'(c) != CHANNELS - 1) begin
                  ch_q <= c + 1'b1;
                end
              end
            end
            4'(CmdToneWr): begin
              if (tc_ok) begin
                if (it_q.address[0]) tp_q[tc][11:8] <= it_q.data[3:0];
                else tp_q[tc][7:0] <= it_q.data;
              end
              ob_v_q <= 1'b1; ob_q <= '{it_q.address, it_q.data, 1'b1};
            end
            4'(CmdPlainWr): begin
              ob_v_q <= 1'b1; ob_q <= '{it_q.address, it_q.data, 1'b1};
            end
            4'(CmdAdsr): if (ok) begin
              if (!it_q.count_a[15]) begin
                mode_q[ic] <= ModeEnabled;
                atk_q[ic] <= sat(it_q.count_a); dec_q[ic] <= sat({1'b0, it_q.count_b});
                sus_q[ic] <= it_q.level; rel_q[ic] <= sat({1'b0, it_q.count_c});
              end else mode_q[ic] <= ModeOff;
            end
            4'(CmdVibrato): if (ok) begin
              if (!it_q.count_a[15]) begin
                von_q[ic] <= 1'b1;
                vrate_q[ic] <= sat(it_q.count_a);
                vdel_q[ic]  <= sat({1'b0, it_q.count_b});
                vcnt_q[ic]  <= sat({1'b0, it_q.count_b});
                vdep_q[ic]  <= it_q.level;
                vstep_q[ic] <= {1'b0, it_q.level[7:1]};
                vdown_q[ic] <= 1'b1;
              end else von_q[ic] <= 1'b0;
            end
            4'(CmdPerc): if (ok) begin
              if ((it_q.data & 8'h81) != 8'd0) begin
                mode_q[ic] <= ModeEnabled; atk_q[ic] <= '0; dec_q[ic] <= '0;
                sus_q[ic] <= {4'd0, vel_q[ic]}; rel_q[ic] <= NB'(1);
              end
              perc_q[ic] <= it_q.data[0];
            end
            default: begin
              // volume, tone set, noise: shared volume unit
              logic app;
              app = (it_q.command == 4'(CmdVolume)) ||
                    (it_q.command == 4'(CmdToneSet) && it_q.retrigger) ||
                    (it_q.command == 4'(CmdNoise) && it_q.data[7]);
              if (it_q.command == 4'(CmdNoise)) begin
                ob_v_q <= 1'b1; ob_q <= '{7'd6, it_q.data & 8'h1f, 1'b1};
                if (ok && (it_q.data & 8'hc0) != 8'd0) rel_q[ic] <= sat({1'b0, it_q.count_c});
              end
              if (ok && it_q.command == 4'(CmdToneSet)) tp_q[ic] <= it_q.period;
              if (ok && app) begin
                vel_q[ic] <= a_r.vel; hw_q[ic] <= a_r.hw;
                if (a_r.vib) begin
                  vcnt_q[ic] <= vdel_q[ic]; vstep_q[ic] <= {1'b0, vdep_q[ic][7:1]};
                  vdown_q[ic] <= 1'b1;
                end
                mode_q[ic] <= a_r.mode; ecnt_q[ic] <= a_r.ecnt;
                if (a_r.setvol) vol_q[ic] <= a_r.vol;
              end
              if (ok) begin
                pend_q[ic] <= pend_q[ic] | {it_q.command == 4'(CmdToneSet),
                                            app && a_r.setvol};
              end
            end
          endcase
        end
        BkEmit: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BkIdle && q_valid_i) it_q <= q_item_i;
  end
endmodule
`default_nettype wire

[rtl/core/psg_envelope_vibrato_engine_core.sv]
`default_nettype none
// back end: a command holds it in the execute state, and in the emit state when it sends a beat
// tick: an envelope walk and a vibrato walk over all channels, then an emit walk; stalls hold it
// throughput: one item at a time in the back end; a 2-beat queue lets the front accept ahead
// tick cost set by the channel walk of the shared envelope/vibrato step and the output register
// reset: asynchronous active low; volumes 255, all other channel state zero, envelopes off
module psg_envelope_vibrato_engine_core #(
  parameter int unsigned CHANNELS   = pev_pkg::ChannelsDefault,
  parameter int unsigned COUNT_BITS = pev_pkg::CountBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pev_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pev_pkg::out_item_t out_item_o
);
  import pev_pkg::*;

  logic     q_valid, q_ready, busy;
  in_item_t q_item;

  pev_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  pev_back #(.CHANNELS(CHANNELS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid_o, .out_ready_i, .out_item_o, .busy_o(busy)
  );

  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> busy)
    else $error("output beat without busy back end");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output beat changed while stalled");
endmodule
`default_nettype wire

[tb/psg_envelope_vibrato_engine_core_tb.sv]
`default_nettype none
module psg_envelope_vibrato_engine_core_tb;
  import pev_pkg::*;

  localparam int unsigned NumCh = 3;
  localparam int unsigned CntMax = 32767;
  localparam int unsigned FlagVol = 1;
  localparam int unsigned FlagPer = 2;
  localparam int unsigned CycleLimit = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  psg_envelope_vibrato_engine_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  vol_q [NumCh];
  logic [11:0] per_q [NumCh];
  logic [3:0]  velo_q [NumCh];
  logic        hwenv_q [NumCh];
  logic        perc_q [NumCh];
  logic [1:0]  pend_q [NumCh];
  mode_e       mode_q [NumCh];
  int unsigned env_cnt [NumCh];
  int unsigned atk_cnt [NumCh];
  int unsigned dec_cnt [NumCh];
  logic [7:0]  sus_lvl [NumCh];
  int unsigned rel_cnt [NumCh];
  logic        vib_on [NumCh];
  int unsigned vib_cnt [NumCh];
  int unsigned vib_rate [NumCh];
  int unsigned vib_dly [NumCh];
  logic [7:0]  vib_depth [NumCh];
  logic [7:0]  vib_pos [NumCh];
  logic        vib_down [NumCh];

  out_item_t   write_q [$];
  int          errors = 0;
  int          cycles = 0;
  int          n_items = 0;
  int          n_writes = 0;
  bit          quiet = 1'b0;

  function automatic int unsigned sat(int unsigned v);
    return (v > CntMax) ? CntMax : v;
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < NumCh; i++) begin
      vol_q[i] = 8'hff; per_q[i] = '0; velo_q[i] = '0; hwenv_q[i] = 0; perc_q[i] = 0;
      pend_q[i] = '0; mode_q[i] = ModeOff; env_cnt[i] = 0; atk_cnt[i] = 0; dec_cnt[i] = 0;
      sus_lvl[i] = '0; rel_cnt[i] = 0; vib_on[i] = 0; vib_cnt[i] = 0; vib_rate[i] = 0;
      vib_dly[i] = 0; vib_depth[i] = '0; vib_pos[i] = '0; vib_down[i] = 0;
    end
  endfunction

  function automatic void push_write(int unsigned a, int unsigned d);
    out_item_t w;
    w.reg_address = a[6:0];
    w.reg_data = d[7:0];
    w.last = 1'b0;
    write_q.push_back(w);
  endfunction

  function automatic void note_volume(int c, logic [7:0] vb);
    logic [3:0] v;
    int nv;
    v = vb[3:0];
    nv = -1;
    hwenv_q[c] = vb[4];
    velo_q[c] = v;
    if (vib_on[c]) begin
      vib_cnt[c] = vib_dly[c]; vib_pos[c] = vib_depth[c] / 2; vib_down[c] = 1;
    end
    if (mode_q[c] != ModeOff) begin
      if (v != 0) begin
        if (atk_cnt[c] != 0) begin
          mode_q[c] = ModeAttack; env_cnt[c] = atk_cnt[c]; nv = 0;
        end else if (dec_cnt[c] != 0) begin
          mode_q[c] = ModeDecay; env_cnt[c] = dec_cnt[c]; nv = v;
        end else begin
          mode_q[c] = ModeSustain; nv = sus_lvl[c];
        end
      end else if (rel_cnt[c] != 0) begin
        mode_q[c] = ModeRelease; env_cnt[c] = rel_cnt[c];
      end else begin
        mode_q[c] = ModeEnabled;
        if (perc_q[c]) return;
        nv = 0;
      end
    end else begin
      if (v == 0 && perc_q[c]) return;
      nv = v;
    end
    if (nv >= 0) begin
      vol_q[c] = nv[7:0];
      pend_q[c] |= 2'(FlagVol);
    end
  endfunction

  function automatic void step_adsr(int c);
    int unsigned cnt;
    int v;
    int cur;
    cnt = (env_cnt[c] != 0) ? env_cnt[c] - 1 : 0;
    v = -1;
    if (cnt == 0) begin
      cur = vol_q[c];
      if (mode_q[c] == ModeAttack) begin
        v = cur + 1;
        if (v >= int'(velo_q[c])) begin
          v = velo_q[c]; mode_q[c] = ModeDecay; cnt = dec_cnt[c];
        end else cnt = atk_cnt[c];
      end else if (mode_q[c] == ModeDecay) begin
        v = cur - 1;
        if (v <= int'(sus_lvl[c])) begin
          v = sus_lvl[c]; mode_q[c] = ModeSustain; cnt = rel_cnt[c];
        end else cnt = dec_cnt[c];
      end else if (mode_q[c] == ModeRelease) begin
        v = cur - 1;
        if (v <= 0) begin
          v = 0; mode_q[c] = ModeEnabled; cnt = atk_cnt[c];
        end else cnt = rel_cnt[c];
      end
    end
    env_cnt[c] = cnt;
    if (v != -1 && vol_q[c] != {4'd0, v[3:0]}) begin
      pend_q[c] |= 2'(FlagVol);
      vol_q[c] = {4'd0, v[3:0]};
    end
  endfunction

  function automatic void step_wobble(int c);
    int unsigned cnt;
    int tp;
    if (!vib_on[c]) return;
    cnt = (vib_cnt[c] != 0) ? vib_cnt[c] - 1 : 0;
    if (cnt == 0) begin
      tp = per_q[c];
      cnt = vib_rate[c];
      vib_pos[c] = vib_pos[c] + 8'd1;
      if (vib_pos[c] >= vib_depth[c]) begin
        vib_pos[c] = '0; vib_down[c] = ~vib_down[c];
      end
      tp += vib_down[c] ? -1 : 1;
      if (tp < 0) tp = 0;
      else if (tp >= 4096) tp = 4095;
      per_q[c] = tp[11:0];
      pend_q[c] |= 2'(FlagPer);
    end
    vib_cnt[c] = cnt;
  endfunction

  // predicts the register writes caused by one command and queues them
  function automatic void predict_writes(in_item_t it);
    int c;
    int tc;
    int n_prev;
    bit ok;
    bit aneg;
    logic [1:0] f;
    c = it.channel;
    ok = c < NumCh;
    aneg = it.count_a[15];
    n_prev = write_q.size();
    case (it.command)
      CmdTick: begin
        for (int i = 0; i < NumCh; i++) step_adsr(i);
        for (int i = 0; i < NumCh; i++) step_wobble(i);
        for (int i = 0; i < NumCh; i++) begin
          f = pend_q[i];
          pend_q[i] = '0;
          if (f & FlagVol) push_write(8 + i, {3'd0, hwenv_q[i], vol_q[i][3:0]});
          if (f & FlagPer) begin
            push_write(2 * i, per_q[i][7:0]);
            push_write(2 * i + 1, per_q[i][11:8]);
          end
        end
      end
      CmdToneWr: begin
        tc = it.address >> 1;
        if (tc < NumCh) begin
          if (it.address[0]) per_q[tc][11:8] = it.data[3:0];
          else per_q[tc][7:0] = it.data;
        end
        push_write(it.address, it.data);
      end
      CmdPlainWr: push_write(it.address, it.data);
      CmdVolume: if (ok) note_volume(c, it.data);
      CmdAdsr: if (ok) begin
        if (!aneg) begin
          mode_q[c] = ModeEnabled;
          atk_cnt[c] = sat(it.count_a[14:0]);
          dec_cnt[c] = sat(it.count_b);
          sus_lvl[c] = it.level;
          rel_cnt[c] = sat(it.count_c);
        end else mode_q[c] = ModeOff;
      end
      CmdVibrato: if (ok) begin
        if (!aneg) begin
          vib_on[c] = 1;
          vib_rate[c] = sat(it.count_a[14:0]);
          vib_dly[c] = sat(it.count_b);
          vib_depth[c] = it.level;
          vib_cnt[c] = vib_dly[c];
          vib_pos[c] = it.level / 2;
          vib_down[c] = 1;
        end else vib_on[c] = 0;
      end
      CmdToneSet: if (ok) begin
        per_q[c] = it.period;
        pend_q[c] |= 2'(FlagPer);
        if (it.retrigger) note_volume(c, {4'd0, velo_q[c]});
      end
      CmdPerc: if (ok) begin
        if ((it.data & 8'h81) != 0) begin
          mode_q[c] = ModeEnabled; atk_cnt[c] = 0; dec_cnt[c] = 0;
          sus_lvl[c] = {4'd0, velo_q[c]}; rel_cnt[c] = sat(1);
        end
        perc_q[c] = it.data[0];
      end
      CmdNoise: begin
        push_write(6, it.data & 8'h1f);
        if (ok) begin
          if ((it.data & 8'hc0) != 0) rel_cnt[c] = sat(it.count_c);
          if (it.data[7]) note_volume(c, {4'd0, velo_q[c]});
        end
      end
      default: ;
    endcase
    if (write_q.size() > n_prev) write_q[write_q.size() - 1].last = 1'b1;
  endfunction

  // one beat in, sometimes with a random idle burst before it unless quiet
  task automatic send_cmd(in_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_item_i <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_writes(it);
    n_items++;
    @(negedge clk_i);
  endtask

  function automatic in_item_t mk(cmd_e cmd, int ch, int d = 0, int a = 0, int b = 0,
                                  int cc = 0, int lv = 0, int per = 0, int rt = 0);
    in_item_t it;
    it = '0;
    it.command = cmd; it.channel = 2'(ch); it.data = 8'(d); it.count_a = 16'(a);
    it.count_b = 15'(b); it.count_c = 15'(cc); it.level = 8'(lv); it.period = 12'(per);
    it.retrigger = 1'(rt);
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom});
    if (it.command > 4'd8 && $urandom_range(0, 7) != 0) it.command = 4'($urandom_range(0, 8));
    if ($urandom_range(0, 5) != 0) it.channel = 2'($urandom_range(0, 2));
    if ($urandom_range(0, 2) != 0) begin
      it.count_a = 16'($urandom_range(0, 4));
      it.count_b = 15'($urandom_range(0, 4));
      it.count_c = 15'($urandom_range(0, 4));
      it.level = 8'($urandom_range(0, 15));
    end
    if (it.command == CmdToneWr && $urandom_range(0, 1)) it.address = 7'($urandom_range(0, 5));
    return it;
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    while (write_q.size() != 0 && cycles < CycleLimit) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_cmd(mk(CmdPlainWr, 0, 8'hff)); send_cmd(mk(CmdPlainWr, 3, 0));
    send_cmd(mk(CmdToneWr, 0, 8'hab)); send_cmd(mk(CmdToneWr, 1, 8'hff));
    send_cmd(mk(CmdVolume, 0, 8'h1f)); send_cmd(mk(CmdVolume, 3, 8'h0f));
    send_cmd(mk(CmdTick, 0));
    send_cmd(mk(CmdAdsr, 1, 0, 2, 32767, 32767, 3));
    send_cmd(mk(CmdVolume, 1, 8'h0c));
    repeat (4) send_cmd(mk(CmdTick, 0));
    send_cmd(mk(CmdVibrato, 2, 0, 1, 0, 0, 2));
    send_cmd(mk(CmdToneSet, 2, 0, 0, 0, 0, 0, 4095, 1));
    repeat (3) send_cmd(mk(CmdTick, 0));
    send_cmd(mk(CmdPerc, 0, 8'h81)); send_cmd(mk(CmdVolume, 0, 0));
    send_cmd(mk(CmdNoise, 0, 8'hff, 0, 0, 32767)); send_cmd(mk(CmdNoise, 3, 8'h40));
    send_cmd(mk(CmdAdsr, 0, 0, -1)); send_cmd(mk(CmdVibrato, 2, 0, -32768));
    send_cmd(mk(cmd_e'(4'd15), 0)); send_cmd(mk(CmdTick, 0));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      send_cmd(rand_item());
      if (i == n / 2) drain();
    end
  endtask

  task automatic test_no_idle(int n);
    quiet = 1'b1;
    for (int i = 0; i < n; i++) send_cmd(rand_item());
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_writes++;
      if (write_q.size() == 0) begin
        $display("%0t: unexpected write %h", $time, out_item_o);
        errors++;
      end else begin
        if (write_q[0].reg_address != out_item_o.reg_address)
          $display("%0t: reg_address exp %0d got %0d", $time, write_q[0].reg_address,
                   out_item_o.reg_address);
        if (write_q[0].reg_data != out_item_o.reg_data)
          $display("%0t: reg_data exp %h got %h", $time, write_q[0].reg_data,
                   out_item_o.reg_data);
        if (write_q[0].last != out_item_o.last)
          $display("%0t: last exp %0b got %0b", $time, write_q[0].last, out_item_o.last);
        if (write_q[0] != out_item_o) errors++;
        void'(write_q.pop_front());
      end
    end
  end

  always @(negedge clk_i) begin
    if (quiet) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("psg_envelope_vibrato_engine_core_tb: done, errors");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(130);
    test_no_idle(40);
    drain();
    if (write_q.size() != 0) errors++;
    $display("covered %0d commands and %0d register writes, all command kinds,",
             n_items, n_writes);
    $display("adsr and vibrato stepping, saturating counts and idle bursts on both sides");
    if (errors == 0) begin
      $display("psg_envelope_vibrato_engine_core_tb: done, clean");
    end else begin
      $display("psg_envelope_vibrato_engine_core_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
